// ----- src/tcse_pkg.sv -----
// Package: shared types and constants for the teaching CPU step engine.
`default_nettype none
package tcse_pkg;
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_SETPC = 2'd2;

  localparam logic [1:0] SCR_NONE  = 2'd0;
  localparam logic [1:0] SCR_WRITE = 2'd1;
  localparam logic [1:0] SCR_CLEAR = 2'd2;

  localparam logic [3:0] OPC_NOP  = 4'h0;
  localparam logic [3:0] OPC_LDM  = 4'h1;
  localparam logic [3:0] OPC_LDI  = 4'h2;
  localparam logic [3:0] OPC_ST   = 4'h3;
  localparam logic [3:0] OPC_MOV  = 4'h4;
  localparam logic [3:0] OPC_ADD  = 4'h5;
  localparam logic [3:0] OPC_FADD = 4'h6;
  localparam logic [3:0] OPC_OR   = 4'h7;
  localparam logic [3:0] OPC_AND  = 4'h8;
  localparam logic [3:0] OPC_XOR  = 4'h9;
  localparam logic [3:0] OPC_ROR  = 4'hA;
  localparam logic [3:0] OPC_JEQ  = 4'hB;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH_HI, ST_FETCH_LO, ST_EXEC, ST_MEM, ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] address;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic [7:0]  pc_after;
    logic [15:0] instruction;
    logic        halted;
    logic [1:0]  screen_action;
    logic [7:0]  screen_byte;
  } rsp_t;

  function automatic logic [12:0] fp_to_fix(input logic [7:0] b);
    logic [11:0] mag;
    begin
      mag = 12'({1'b1, b[3:0]}) << b[6:4];
      fp_to_fix = b[7] ? -{1'b0, mag} : {1'b0, mag};
    end
  endfunction

  function automatic logic [7:0] fix_to_fp(input logic [13:0] v);
    logic        sgn;
    logic [12:0] mag;
    logic [3:0]  p;
    logic        found;
    logic [12:0] sh;
    begin
      sgn = v[13];
      mag = sgn ? 13'(-v) : v[12:0];
      p = 4'd0;
      found = 1'b0;
      for (int i = 0; i < 13; i++) begin
        if (mag[i]) begin
          p = 4'(i);
          found = 1'b1;
        end
      end
      sh = mag >> (p - 4'd4);
      if (!found || p < 4'd4) fix_to_fp = 8'h00;
      else if (p > 4'd11) fix_to_fp = {sgn, 7'h7F};
      else fix_to_fp = {sgn, 3'(p - 4'd4), sh[3:0]};
    end
  endfunction
endpackage
`default_nettype wire

// ----- src/tcse_if.sv -----
// Interface: valid/ready request channel carrying a payload.
`default_nettype none
interface tcse_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- src/tcse_alu.sv -----
// ALU: register operations and the 8-bit float adder.
`default_nettype none
module tcse_alu import tcse_pkg::*; (
  input  wire logic [3:0] opc,
  input  wire logic [7:0] rv,
  input  wire logic [7:0] sv,
  input  wire logic [7:0] tv,
  input  wire logic [2:0] rot,
  output logic [7:0]      res
);
  logic [12:0] sfix, tfix;
  logic [13:0] fsum;
  logic [15:0] rr;
  assign sfix = fp_to_fix(sv);
  assign tfix = fp_to_fix(tv);
  assign fsum = {sfix[12], sfix} + {tfix[12], tfix};
  assign rr = {rv, rv} >> rot;
  always_comb begin
    unique case (opc)
      OPC_ADD:  res = sv + tv;
      OPC_FADD: res = fix_to_fp(fsum);
      OPC_OR:   res = sv | tv;
      OPC_AND:  res = sv & tv;
      OPC_XOR:  res = sv ^ tv;
      OPC_ROR:  res = rr[7:0];
      default:  res = sv;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/teaching_cpu_step_engine_unit.sv -----
// Top level: teaching CPU step engine with memory and register file in RAM.
// A memory write or set-pc result is valid the cycle after accept; an execute result
// passes FETCH_HI, FETCH_LO, EXEC and MEM (two byte fetches, register read, data
// access and writeback) before DONE. One request at a time; the next is taken the
// cycle after the result leaves, and none is taken while a result waits in DONE.
// Reset clears pc and control and sets the noop config bit, then a pass over all 256
// addresses zeroes memory and register file before the first request is taken.
`default_nettype none
module teaching_cpu_step_engine_unit import tcse_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  tcse_if.sink      in_ch,
  tcse_if.source    out_ch
);
  logic [7:0] mem [256];
  logic [7:0] rf [16];
  state_t     state_r, state_nxt;
  logic       clr_r;
  logic [7:0] clr_cnt_r;
  logic       noop_r;
  logic [7:0] pc_r;
  req_t       req_r;
  rsp_t       rsp_r;
  logic [15:0] ins_r;
  logic [7:0] mrd_r;
  logic [7:0] rv_r, sv_r, tv_r, r0_r;
  logic [7:0] alu_res;

  logic       mwe;
  logic [7:0] maddr, mwd;
  logic       rwe;
  logic [3:0] raddr;
  logic [7:0] rwd;

  wire [3:0] opc = ins_r[15:12];
  wire [3:0] ri = ins_r[11:8];
  wire [3:0] si = ins_r[7:4];
  wire [3:0] ti = ins_r[3:0];
  wire [7:0] xy = ins_r[7:0];

  tcse_alu u_alu (.opc(opc), .rv(rv_r), .sv(sv_r), .tv(tv_r), .rot(ti[2:0]),
    .res(alu_res));

  assign in_ch.ready = !clr_r && state_r == ST_IDLE;
  assign out_ch.valid = state_r == ST_DONE;
  assign out_ch.payload = rsp_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_ch.valid && in_ch.ready)
                     state_nxt = in_ch.payload.op == OP_EXEC ? ST_FETCH_HI : ST_DONE;
      ST_FETCH_HI: state_nxt = ST_FETCH_LO;
      ST_FETCH_LO: state_nxt = ST_EXEC;
      ST_EXEC:     state_nxt = ST_MEM;
      ST_MEM:      state_nxt = ST_DONE;
      ST_DONE:     if (out_ch.ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // memory port: one access a cycle
  always_comb begin
    mwe = 1'b0; maddr = pc_r; mwd = req_r.data;
    rwe = 1'b0; raddr = ri; rwd = alu_res;
    priority if (clr_r) begin
      mwe = 1'b1; maddr = clr_cnt_r; mwd = 8'h00;
      rwe = 1'b1; raddr = clr_cnt_r[3:0]; rwd = 8'h00;
    end else if (state_r == ST_IDLE && in_ch.valid && in_ch.payload.op == OP_WRITE) begin
      mwe = 1'b1; maddr = in_ch.payload.address; mwd = in_ch.payload.data;
    end else if (state_r == ST_IDLE) begin
      maddr = pc_r;
    end else if (state_r == ST_FETCH_HI) begin
      maddr = pc_r + 8'd1;
    end else if (state_r == ST_EXEC) begin
      maddr = xy;
    end else if (state_r == ST_MEM) begin
      maddr = xy;
      if (opc == OPC_ST) begin
        mwe = 1'b1; mwd = rv_r;
      end
      unique case (opc)
        OPC_LDM: begin rwe = 1'b1; rwd = mrd_r; end
        OPC_LDI: begin rwe = 1'b1; rwd = xy; end
        OPC_MOV: begin rwe = 1'b1; raddr = ti; rwd = sv_r; end
        OPC_ADD, OPC_FADD, OPC_OR, OPC_AND, OPC_XOR, OPC_ROR: rwe = 1'b1;
        default: rwe = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwd;
    mrd_r <= mem[maddr];
    if (rwe) rf[raddr] <= rwd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      clr_r <= 1'b1;
      clr_cnt_r <= 8'd0;
      noop_r <= 1'b1;
      pc_r <= 8'd0;
    end else begin
      state_r <= state_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 8'd1;
        if (clr_cnt_r == 8'hFF) clr_r <= 1'b0;
      end
      if (cfg_we) noop_r <= cfg_wdata;
      if (state_r == ST_IDLE && in_ch.valid && in_ch.ready && in_ch.payload.op == OP_SETPC)
        pc_r <= in_ch.payload.address;
      if (state_r == ST_FETCH_LO) pc_r <= pc_r + 8'd2;
      if (state_r == ST_MEM && opc == OPC_JEQ && rv_r == r0_r) pc_r <= {xy[7:1], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid && in_ch.ready) req_r <= in_ch.payload;
    if (state_r == ST_FETCH_HI) ins_r[15:8] <= mrd_r;
    if (state_r == ST_FETCH_LO) ins_r[7:0] <= mrd_r;
    if (state_r == ST_EXEC) begin
      rv_r <= rf[ri]; sv_r <= rf[si]; tv_r <= rf[ti]; r0_r <= rf[4'd0];
    end
    unique case (state_r)
      ST_IDLE: begin
        rsp_r <= '{pc_after: (in_ch.payload.op == OP_SETPC) ? in_ch.payload.address : pc_r,
                   instruction: 16'h0000, halted: 1'b0, screen_action: SCR_NONE,
                   screen_byte: 8'h00};
      end
      ST_MEM: begin
        rsp_r.instruction <= ins_r;
        rsp_r.pc_after <= (opc == OPC_JEQ && rv_r == r0_r) ? {xy[7:1], 1'b0} : pc_r;
        rsp_r.halted <= (opc == OPC_NOP) ? !noop_r : (opc > OPC_JEQ);
        if (opc == OPC_ST && xy == 8'h00) begin
          rsp_r.screen_action <= (rv_r != 8'h00) ? SCR_WRITE : SCR_CLEAR;
          rsp_r.screen_byte <= rv_r;
        end
      end
      default: ;
    endcase
  end

  // ST_EXEC reads rf before writeback; rf read in EXEC registered so move at MEM
`ifndef SYNTHESIS
  a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_ch.ready) else $error("accept during clear");
  a_fetch_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FETCH_HI |=> state_r == ST_FETCH_LO) else $error("fetch order");
  a_pc_adv: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FETCH_LO |=> pc_r == $past(pc_r) + 8'd2) else $error("pc advance");
`endif
endmodule
`default_nettype wire
